// ----- rtl/bsm_pkg.sv -----
package bsm_pkg;

  typedef enum logic [2:0] {
    CMD_CPU_RD  = 3'd0,
    CMD_CPU_WR  = 3'd1,
    CMD_PPU_RD  = 3'd2,
    CMD_PPU_WR  = 3'd3,
    CMD_LINE    = 3'd4,
    CMD_IRQ_CLR = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    REGION_NONE   = 2'd0,
    REGION_MEM    = 2'd1,
    REGION_PRAM   = 2'd2,
    REGION_MAPPER = 2'd3
  } region_e;

  // configuration register indexes
  localparam logic CFG_PRG_BANKS = 1'b0;
  localparam logic CFG_CHR_BANKS = 1'b1;

  localparam logic [7:0] PRG_BANKS_RST = 8'd2;
  localparam logic [7:0] CHR_BANKS_RST = 8'd0;

  // cpu address window, address[15:13]
  localparam logic [2:0] WIN_PRAM = 3'b011;
  // mapper register group, address[14:13]
  localparam logic [1:0] GRP_BANK   = 2'd0;
  localparam logic [1:0] GRP_MIRROR = 2'd1;
  localparam logic [1:0] GRP_LINE   = 2'd2;
  localparam logic [1:0] GRP_IRQ    = 2'd3;

  localparam int unsigned PRG_BANK_W = 6;
  localparam int unsigned MAP_W      = 22;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [1:0]        region;
    logic [MAP_W-1:0]  mapped_address;
    logic              mirror_valid;
    logic              mirror_horizontal;
    logic              irq_line;
  } result_t;

  typedef struct packed {
    logic [7:0][7:0] bank_sel;
    logic [2:0]      sel_idx;
    logic            prg_mode;
    logic            chr_mode;
    logic [7:0]      line_cnt;
    logic [7:0]      line_reload;
    logic            reload_pend;
    logic            irq_en;
    logic            irq_pend;
    logic [7:0]      prg_banks;
    logic [7:0]      chr_banks;
  } state_t;

endpackage

// ----- rtl/bsm_in_if.sv -----
interface bsm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output command, output address, output write_data,
                  input ready);
  modport sink (input valid, input command, input address, input write_data,
                output ready);
endinterface

// ----- rtl/bsm_out_if.sv -----
interface bsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  region;
  logic [21:0] mapped_address;
  logic        mirror_valid;
  logic        mirror_horizontal;
  logic        irq_line;

  modport source (output valid, output region, output mapped_address,
                  output mirror_valid, output mirror_horizontal, output irq_line,
                  input ready);
  modport sink (input valid, input region, input mapped_address,
                input mirror_valid, input mirror_horizontal, input irq_line,
                output ready);
endinterface

// ----- rtl/bank_switch_mapper_with_scanline_irq.sv -----
// channel  | dir | handshake    | payload
// in_bus   | in  | valid/ready  | command, address, write_data
// out_bus  | out | valid/ready  | region, mapped_address, mirror_*, irq_line
// cfg_*    | in  | write enable | cfg_index, cfg_data (no read-back)
//
// one beat per cycle sustained while out_bus.ready is high; a beat passes the
// input register and then the result register, via one translate/update stage.
// rst_n is synchronous: clears handshake valids, bank and irq state, and loads
// the configuration defaults. a stalled result holds in the output register
// while the input register keeps the next beat; in_bus.ready drops only then.
module bank_switch_mapper_with_scanline_irq (
  input  logic            clk,
  input  logic            rst_n,
  bsm_in_if.sink          in_bus,
  bsm_out_if.source       out_bus,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data
);
  import bsm_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    advance, s1_take;
  state_t  st;
  logic    irq_nxt;
  result_t res;

  assign advance      = !out_valid_r || out_bus.ready;
  assign s1_take      = s1_valid_r && advance;
  assign in_bus.ready = !s1_valid_r || advance;

  bsm_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .upd       (s1_take),
    .item      (s1_item_r),
    .st        (st),
    .irq_nxt   (irq_nxt)
  );

  bsm_xlate u_xlate (
    .item    (s1_item_r),
    .st      (st),
    .irq_nxt (irq_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_item_r <= '{command: in_bus.command, address: in_bus.address,
                     write_data: in_bus.write_data};
    end
    if (s1_take) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.region            = out_res_r.region;
  assign out_bus.mapped_address    = out_res_r.mapped_address;
  assign out_bus.mirror_valid      = out_res_r.mirror_valid;
  assign out_bus.mirror_horizontal = out_res_r.mirror_horizontal;
  assign out_bus.irq_line          = out_res_r.irq_line;

`ifndef SYNTHESIS
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_bus.ready |=> s1_valid_r)
    else $error("input stage dropped a beat under stall");
  a_mapper_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.region == REGION_MAPPER |-> out_res_r.mapped_address == '0)
    else $error("register write carries an address");
  a_mirror_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.mirror_valid |-> out_res_r.region == REGION_MAPPER)
    else $error("mirroring update outside a register write");
  a_irq_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st.irq_pend) |-> $past(st.irq_en))
    else $error("irq raised while disabled");
`endif

endmodule

// ----- rtl/bsm_state.sv -----
module bsm_state (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            upd,
  input  bsm_pkg::item_t  item,
  output bsm_pkg::state_t st,
  output logic            irq_nxt
);
  import bsm_pkg::*;

  state_t st_r, st_nxt;
  state_t st_rst;
  logic   odd;
  logic [7:0] cnt_tick;

  assign odd = item.address[0];

  always_comb begin
    st_rst           = '0;
    st_rst.prg_banks = PRG_BANKS_RST;
    st_rst.chr_banks = CHR_BANKS_RST;
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_tick = st_r.line_cnt;
    if (upd) begin
      case (cmd_e'(item.command))
        CMD_CPU_WR: begin
          if (item.address[15]) begin
            case (item.address[14:13])
              GRP_BANK: begin
                if (!odd) begin
                  st_nxt.sel_idx  = item.write_data[2:0];
                  st_nxt.prg_mode = item.write_data[6];
                  st_nxt.chr_mode = item.write_data[7];
                end else begin
                  st_nxt.bank_sel[st_r.sel_idx] = item.write_data;
                end
              end
              GRP_LINE: begin
                if (!odd) begin
                  st_nxt.line_reload = item.write_data;
                end else begin
                  st_nxt.line_cnt    = 8'd0;
                  st_nxt.reload_pend = 1'b1;
                end
              end
              GRP_IRQ: begin
                if (!odd) begin
                  st_nxt.irq_en   = 1'b0;
                  st_nxt.irq_pend = 1'b0;
                end else begin
                  st_nxt.irq_en = 1'b1;
                end
              end
              default: begin
                // mirroring writes change no state here
              end
            endcase
          end
        end
        CMD_LINE: begin
          if (st_r.line_cnt == 8'd0 || st_r.reload_pend) begin
            cnt_tick           = st_r.line_reload;
            st_nxt.reload_pend = 1'b0;
          end else begin
            cnt_tick = st_r.line_cnt - 8'd1;
          end
          st_nxt.line_cnt = cnt_tick;
          if (cnt_tick == 8'd0 && st_r.irq_en) begin
            st_nxt.irq_pend = 1'b1;
          end
        end
        CMD_IRQ_CLR: begin
          st_nxt.irq_pend = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (cfg_we) begin
      if (cfg_index == CFG_PRG_BANKS) begin
        st_nxt.prg_banks = cfg_data;
      end else begin
        st_nxt.chr_banks = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st      = st_r;
  assign irq_nxt = st_nxt.irq_pend;

endmodule

// ----- rtl/bsm_xlate.sv -----
module bsm_xlate (
  input  bsm_pkg::item_t   item,
  input  bsm_pkg::state_t  st,
  input  logic             irq_nxt,
  output bsm_pkg::result_t res
);
  import bsm_pkg::*;

  logic [8:0]            n_last, n_prev, prg_bank;
  logic [PRG_BANK_W-1:0] r6, r7;
  logic [1:0]            pslot;
  logic [2:0]            cslot;
  logic [2:0]            cidx;
  logic [7:0]            chr_bank;
  logic [MAP_W-1:0]      prg_off, chr_off;
  logic                  is_pram;

  always_comb begin
    n_last = {st.prg_banks, 1'b0} - 9'd1;
    n_prev = {st.prg_banks, 1'b0} - 9'd2;
    r6     = st.bank_sel[6][PRG_BANK_W-1:0];
    r7     = st.bank_sel[7][PRG_BANK_W-1:0];
    pslot  = item.address[14:13];
    if (pslot == 2'd3) begin
      prg_bank = n_last;
    end else if (pslot == 2'd1) begin
      prg_bank = {3'd0, r7};
    end else if ((pslot == 2'd0) == !st.prg_mode) begin
      prg_bank = {3'd0, r6};
    end else begin
      prg_bank = n_prev;
    end
    prg_off = {prg_bank, item.address[12:0]};

    // inversion swaps the 2 KiB and 1 KiB halves
    cslot = item.address[12:10] ^ {st.chr_mode, 2'b00};
    cidx  = cslot - 3'd2;
    if (cslot < 3'd2) begin
      chr_bank = {st.bank_sel[0][7:1], cslot[0]};
    end else if (cslot < 3'd4) begin
      chr_bank = {st.bank_sel[1][7:1], cslot[0]};
    end else begin
      chr_bank = st.bank_sel[cidx];
    end
    chr_off = {4'd0, chr_bank, item.address[9:0]};

    is_pram = (item.address[15:13] == WIN_PRAM);

    res                   = '0;
    res.irq_line          = irq_nxt;
    case (cmd_e'(item.command))
      CMD_CPU_RD: begin
        if (is_pram) begin
          res.region         = REGION_PRAM;
          res.mapped_address = {9'd0, item.address[12:0]};
        end else if (item.address[15]) begin
          res.region         = REGION_MEM;
          res.mapped_address = prg_off;
        end
      end
      CMD_CPU_WR: begin
        if (is_pram) begin
          res.region         = REGION_PRAM;
          res.mapped_address = {9'd0, item.address[12:0]};
        end else if (item.address[15]) begin
          res.region = REGION_MAPPER;
          if (item.address[14:13] == GRP_MIRROR && !item.address[0]) begin
            res.mirror_valid      = 1'b1;
            res.mirror_horizontal = item.write_data[0];
          end
        end
      end
      CMD_PPU_RD: begin
        if (item.address[15:13] == 3'd0) begin
          res.region         = REGION_MEM;
          res.mapped_address = chr_off;
        end
      end
      CMD_PPU_WR: begin
        if (item.address[15:13] == 3'd0 && st.chr_banks == 8'd0) begin
          res.region         = REGION_MEM;
          res.mapped_address = chr_off;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
